// File: rtl/core/aes_cbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC codec package
// Shared types, constants and byte-level AES functions.
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

  localparam int unsigned BlkBytes  = 16;
  localparam int unsigned NumRounds = 14;
  localparam int unsigned RkWords   = 30;
  localparam int unsigned RkAw      = 5;
  localparam int unsigned CfgAw     = 3;

  typedef enum logic [CfgAw-1:0] {
    CFG_MODE  = 3'd0,
    CFG_KEY0  = 3'd1,
    CFG_KEY1  = 3'd2,
    CFG_KEY2  = 3'd3,
    CFG_KEY3  = 3'd4,
    CFG_IVHI  = 3'd5,
    CFG_IVLO  = 3'd6,
    CFG_SPARE = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_LOAD,
    ST_ROUND,
    ST_OUT,
    ST_PAD
  } cdc_state_e;

  // key expansion status/control shared between sequencer and expander
  typedef struct packed {
    logic start;
    logic busy;
  } kexp_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // state byte i sits at bits [127-8i -: 8]
  function automatic logic [7:0] sb(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = sbox(sb(s, r + 4*((c + r) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb(t, 4*c); a1 = sb(t, 4*c+1); a2 = sb(t, 4*c+2); a3 = sb(t, 4*c+3);
      m[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      m[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      m[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return last ? t : m;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    return p;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sb(s, 4*c); a1 = sb(s, 4*c+1); a2 = sb(s, 4*c+2); a3 = sb(s, 4*c+3);
      m[127-8*(4*c)   -: 8] = gm(a0, 4'd14) ^ gm(a1, 4'd11) ^ gm(a2, 4'd13) ^ gm(a3, 4'd9);
      m[127-8*(4*c+1) -: 8] = gm(a0, 4'd9) ^ gm(a1, 4'd14) ^ gm(a2, 4'd11) ^ gm(a3, 4'd13);
      m[127-8*(4*c+2) -: 8] = gm(a0, 4'd13) ^ gm(a1, 4'd9) ^ gm(a2, 4'd14) ^ gm(a3, 4'd11);
      m[127-8*(4*c+3) -: 8] = gm(a0, 4'd11) ^ gm(a1, 4'd13) ^ gm(a2, 4'd9) ^ gm(a3, 4'd14);
    end
    return m;
  endfunction

  // inverse shift rows and inverse sub bytes
  function automatic logic [127:0] inv_sr_sb(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = inv_sbox(sb(s, r + 4*((c + 4 - r) % 4)));
      end
    end
    return t;
  endfunction

endpackage

// File: rtl/core/aes_cbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC stream interfaces
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
interface aes_cbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic [4:0]  byte_count;
  logic        final_block;

  modport source (output valid, block_high, block_low, byte_count, final_block, input ready);
  modport sink   (input valid, block_high, block_low, byte_count, final_block, output ready);
endinterface

interface aes_cbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic [4:0]  valid_bytes;
  logic        run_end;
  logic        pad_error;

  modport source (output valid, result_high, result_low, valid_bytes, run_end, pad_error,
                  input ready);
  modport sink   (input valid, result_high, result_low, valid_bytes, run_end, pad_error,
                  output ready);
endinterface

// File: rtl/core/aes_cbc_kexp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC key expander
// Produces the 30 round-key double words one per cycle from the key words.
// ----------------------------------------------------------------------------
module aes_cbc_kexp
  import aes_cbc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [255:0]     key_i,
  output kexp_ctrl_t       stat_o,
  output logic             we_o,
  output logic [RkAw-1:0]  waddr_o,
  output logic [63:0]      wdata_o
);

  // eight-word sliding window of the schedule
  logic [255:0]    win_q, win_d;
  logic [RkAw-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [7:0]      rc_q, rc_d;
  logic [31:0]     t0, t1, n0, n1;

  always_comb begin
    t0 = win_q[31:0];
    t0 = sub_word({t0[23:0], t0[31:24]}) ^ {rc_q, 24'h0};
    n0 = win_q[255:224] ^ t0;
    n1 = win_q[223:192] ^ n0;
  end

  // second pair of the group uses sub_word without rotation
  logic [31:0] m0, m1, m2, m3, m4, m5;
  always_comb begin
    m0 = win_q[191:160] ^ n1;
    m1 = win_q[159:128] ^ m0;
    m2 = win_q[127:96] ^ sub_word(m1);
    m3 = win_q[95:64] ^ m2;
    m4 = win_q[63:32] ^ m3;
    m5 = win_q[31:0]  ^ m4;
    t1 = m5;
  end

  // sequence: cnt 0..3 emit key, then each group of 4 emits from a new window
  logic [1:0]  ph;
  assign ph = cnt_q[1:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    win_d  = win_q;
    rc_d   = rc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      win_d  = key_i;
      rc_d   = 8'h01;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == RkAw'(RkWords - 1)) busy_d = 1'b0;
      // roll to the next eight words after the fourth double word
      if (ph == 2'd3) begin
        win_d = {n0, n1, m0, m1, m2, m3, m4, t1};
        rc_d  = xt(rc_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    rc_q  <= rc_d;
  end

  assign stat_o.start = start_i;
  assign stat_o.busy  = busy_q;
  assign we_o    = busy_q;
  assign waddr_o = cnt_q;
  assign wdata_o = win_q[255 - 64*ph -: 64];

endmodule

// File: rtl/core/aes_cbc_rkram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC round-key memory
// Synchronous single-write, dual-read store of the 30 round-key double words.
// ----------------------------------------------------------------------------
module aes_cbc_rkram
  import aes_cbc_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [RkAw-1:0] waddr_i,
  input  logic [63:0]     wdata_i,
  input  logic [RkAw-1:0] raddr_a_i,
  input  logic [RkAw-1:0] raddr_b_i,
  output logic [63:0]     rdata_a_o,
  output logic [63:0]     rdata_b_o
);

  logic [63:0] mem_q [RkWords];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/core/aes256_cbc_pkcs7_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC codec with PKCS#7 padding
// Encrypts or decrypts 16-byte blocks with one shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one message block per item; final_block marks the last.
//   out_if returns result blocks; an encrypt of a full final block returns
//   two items, the second being the padding block with run_end set.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle; key and IV are taken when the next message starts.
// Sequence:
//   A block passes a load step, the shared round unit (14 rounds and the
//   final key add, each fed by a round key read a step ahead) and an
//   output step. The first block of a message waits for key expansion
//   first. The padding block follows the first result through its own pad,
//   load, round and output steps. A new item is accepted only once the last
//   one is through and its result has been taken.
// Reset:
//   rst_ni clears the control state, chain value, configuration and the
//   in-message flag; the round-key memory is filled at each message start.
// Stall:
//   A result waits in the output register until taken; a padding block holds
//   its final step behind it, and the next item waits until the result left.
// ----------------------------------------------------------------------------
module aes256_cbc_pkcs7_codec
  import aes_cbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgAw-1:0]  cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  aes_cbc_in_if.sink        in_if,
  aes_cbc_out_if.source     out_if
);

  // configuration registers
  logic         mode_q;
  logic [255:0] key_q;
  logic [127:0] iv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      key_q  <= '0;
      iv_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:  mode_q          <= cfg_data_i[0];
        CFG_KEY0:  key_q[255:192]  <= cfg_data_i;
        CFG_KEY1:  key_q[191:128]  <= cfg_data_i;
        CFG_KEY2:  key_q[127:64]   <= cfg_data_i;
        CFG_KEY3:  key_q[63:0]     <= cfg_data_i;
        CFG_IVHI:  iv_q[127:64]    <= cfg_data_i;
        CFG_IVLO:  iv_q[63:0]      <= cfg_data_i;
        CFG_SPARE: ;
        default:   ;
      endcase
    end
  end

  // key expander and round-key memory
  kexp_ctrl_t      kx;
  logic            kx_start;
  logic            rk_we;
  logic [RkAw-1:0] rk_waddr, rk_ra, rk_rb;
  logic [63:0]     rk_wdata, rk_da, rk_db;

  aes_cbc_kexp u_kexp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kx_start),
    .key_i   (key_q),
    .stat_o  (kx),
    .we_o    (rk_we),
    .waddr_o (rk_waddr),
    .wdata_o (rk_wdata)
  );

  aes_cbc_rkram u_rkram (
    .clk_i     (clk_i),
    .we_i      (rk_we),
    .waddr_i   (rk_waddr),
    .wdata_i   (rk_wdata),
    .raddr_a_i (rk_ra),
    .raddr_b_i (rk_rb),
    .rdata_a_o (rk_da),
    .rdata_b_o (rk_db)
  );

  // sequencer state
  cdc_state_e   st_q, st_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [127:0] s_q, s_d;
  logic [127:0] chain_q, chain_d;
  logic         inmsg_q, inmsg_d;
  logic         dec_q, dec_d;
  logic         fin_q, fin_d;
  logic         pad2_q, pad2_d;
  logic [127:0] prev_q, prev_d;
  logic         ov_q, ov_d;
  logic [127:0] o_blk_q, o_blk_d;
  logic [4:0]   o_vb_q, o_vb_d;
  logic         o_end_q, o_end_d, o_err_q, o_err_d;

  logic         acc;
  logic [127:0] rk;
  logic [127:0] in_blk, pad_blk;
  logic [4:0]   n_sat;
  logic [127:0] dec_out;
  logic [7:0]   pb;

  assign acc    = in_if.valid & in_if.ready;
  assign in_blk = {in_if.block_high, in_if.block_low};
  assign rk     = {rk_da, rk_db};
  assign n_sat  = (in_if.byte_count > 5'd16) ? 5'd16 : in_if.byte_count;

  // PKCS#7 fill of the tail bytes
  always_comb begin
    pad_blk = in_blk;
    for (int i = 0; i < BlkBytes; i++) begin
      if (5'(i) >= n_sat) pad_blk[127-8*i -: 8] = 8'(5'd16 - n_sat);
    end
  end

  assign dec_out = s_q ^ rk ^ prev_q;
  assign pb      = dec_out[7:0];

  // round-key read address for the next step: encrypt counts up, decrypt down
  logic [3:0] rstep, rsel;
  always_comb begin
    rstep = (st_d == ST_ROUND) ? rnd_d - 4'd1 : 4'd0;
    rsel  = dec_d ? 4'(NumRounds) - rstep : rstep;
    rk_ra = {rsel, 1'b0};
    rk_rb = {rsel, 1'b1};
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (acc) st_d = inmsg_q ? ST_LOAD : ST_KEXP;
      ST_KEXP:  if (!kx.busy && !kx.start) st_d = ST_LOAD;
      ST_LOAD:  st_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == 4'(NumRounds + 1) && (!ov_q || out_if.ready)) st_d = ST_OUT;
      end
      ST_OUT:   if (!ov_q || out_if.ready) st_d = pad2_q ? ST_PAD : ST_IDLE;
      ST_PAD:   st_d = ST_LOAD;
      default:  st_d = ST_IDLE;
    endcase
  end

  // datapath and control updates
  always_comb begin
    rnd_d   = rnd_q;
    s_d     = s_q;
    chain_d = chain_q;
    inmsg_d = inmsg_q;
    dec_d   = dec_q;
    fin_d   = fin_q;
    pad2_d  = pad2_q;
    prev_d  = prev_q;
    ov_d    = ov_q & ~out_if.ready;
    o_blk_d = o_blk_q;
    o_vb_d  = o_vb_q;
    o_end_d = o_end_q;
    o_err_d = o_err_q;
    kx_start = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (acc) begin
          kx_start = !inmsg_q;
          inmsg_d  = !in_if.final_block;
          dec_d    = mode_q;
          fin_d    = in_if.final_block;
          pad2_d   = !mode_q && in_if.final_block && (n_sat == 5'd16);
          s_d      = (!mode_q && in_if.final_block) ? pad_blk : in_blk;
          if (!inmsg_q) chain_d = iv_q;
        end
      end
      ST_KEXP: ;
      ST_LOAD: begin
        rnd_d = 4'd1;
        if (dec_q) begin
          prev_d  = chain_q;
          chain_d = s_q;
        end else begin
          s_d = s_q ^ chain_q;
        end
      end
      ST_ROUND: begin
        if (rnd_q != 4'(NumRounds + 1)) begin
          rnd_d = rnd_q + 4'd1;
          if (dec_q) begin
            if (rnd_q == 4'd1) s_d = inv_sr_sb(s_q ^ rk);
            else s_d = inv_sr_sb(inv_mix(s_q ^ rk));
          end else begin
            s_d = enc_round(s_q ^ rk, rnd_q == 4'(NumRounds));
          end
        end else if (!ov_q || out_if.ready) begin
          // final key add; hold here while an earlier result still waits
          if (dec_q) begin
            o_blk_d = dec_out;
            o_end_d = fin_q;
            o_err_d = fin_q && (pb == 8'd0 || pb > 8'd16);
            o_vb_d  = (fin_q && !(pb == 8'd0 || pb > 8'd16)) ? 5'(8'd16 - pb) : 5'd16;
          end else begin
            o_blk_d = s_q ^ rk;
            chain_d = s_q ^ rk;
            o_end_d = fin_q && !pad2_q;
            o_err_d = 1'b0;
            o_vb_d  = 5'd16;
          end
        end
      end
      ST_OUT: begin
        if (!ov_q || out_if.ready) ov_d = 1'b1;
      end
      ST_PAD: begin
        pad2_d = 1'b0;
        s_d    = {BlkBytes{8'h10}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      rnd_q   <= '0;
      chain_q <= '0;
      inmsg_q <= 1'b0;
      dec_q   <= 1'b0;
      fin_q   <= 1'b0;
      pad2_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      rnd_q   <= rnd_d;
      chain_q <= chain_d;
      inmsg_q <= inmsg_d;
      dec_q   <= dec_d;
      fin_q   <= fin_d;
      pad2_q  <= pad2_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    prev_q  <= prev_d;
    o_blk_q <= o_blk_d;
    o_vb_q  <= o_vb_d;
    o_end_q <= o_end_d;
    o_err_q <= o_err_d;
  end

  // handshake outputs
  assign in_if.ready        = (st_q == ST_IDLE) && !ov_q;
  assign out_if.valid       = ov_q;
  assign out_if.result_high = o_blk_q[127:64];
  assign out_if.result_low  = o_blk_q[63:0];
  assign out_if.valid_bytes = o_vb_q;
  assign out_if.run_end     = o_end_q;
  assign out_if.pad_error   = o_err_q;

endmodule

// File: rtl/core/aes_cbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC codec port checker
// Watches the top-level channels for ordering and stall behaviour.
// ----------------------------------------------------------------------------
module aes_cbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_high_i,
  input logic [4:0]  out_vb_i,
  input logic        out_err_i
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_high_i))
    else $error("stalled result changed");

  // take no item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken while result pending");

  // an accepted item needs at least a round sequence before its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i ##1 !out_valid_i)
    else $error("result too early");

  // a pad error reports a full block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i |-> out_vb_i == 5'd16)
    else $error("pad error with short count");

endmodule

bind aes256_cbc_pkcs7_codec aes_cbc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_high_i  (out_if.result_high),
  .out_vb_i    (out_if.valid_bytes),
  .out_err_i   (out_if.pad_error)
);

// File: tb/codec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC codec checker
// Watches the configuration port and both stream channels. For each
// accepted input item it computes the expected output items and queues
// them. Each accepted output item is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module codec_checker
  import aes_cbc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgAw-1:0] cfg_idx_i,
  input  logic [63:0]      cfg_data_i,
  aes_cbc_in_if            in_mon,
  aes_cbc_out_if           out_mon,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct {
    logic [63:0] res_hi;
    logic [63:0] res_lo;
    logic [4:0]  vbytes;
    logic        last;
    logic        perr;
  } codec_out_t;

  codec_out_t  expected_q[$];

  logic [7:0]  fwd_sub [256];
  logic [7:0]  inv_sub [256];

  logic        dec_mode;
  logic [63:0] key_w [4];
  logic [63:0] iv_hi, iv_lo;
  logic [63:0] rkey [30];
  logic [127:0] chain;
  logic        in_msg;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // build the substitution tables from the field inverse and affine map
  initial begin
    logic [7:0] inv8, s, rot;
    for (int x = 0; x < 256; x++) begin
      inv8 = '0;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv8 = y[7:0];
      end
      s   = inv8 ^ 8'h63;
      rot = inv8;
      for (int k = 0; k < 4; k++) begin
        rot = {rot[6:0], rot[7]};
        s   = s ^ rot;
      end
      fwd_sub[x] = s;
      inv_sub[s] = x[7:0];
    end
  end

  function automatic logic [31:0] sub_word32(logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = key_w[i][63:32];
      w[2*i+1] = key_w[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t  = sub_word32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end else if (i % 8 == 4) begin
        t = sub_word32(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int i = 0; i < 30; i++) rkey[i] = {w[2*i], w[2*i+1]};
  endfunction

  function automatic logic [127:0] round_key(int r);
    return {rkey[2*r], rkey[2*r+1]};
  endfunction

  // substitute and shift rows in one pass; both steps commute
  function automatic logic [127:0] sub_shift(logic [127:0] s, bit inverse);
    logic [127:0] t;
    logic [7:0]   b;
    int           src;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inverse ? r + 4*((c + 4 - r) % 4) : r + 4*((c + r) % 4);
        b   = s[127-8*src -: 8];
        t[127-8*(r+4*c) -: 8] = inverse ? inv_sub[b] : fwd_sub[b];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s, bit inverse);
    logic [127:0] m;
    logic [7:0]   coef [4];
    logic [7:0]   acc;
    if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else         coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul(s[127-8*(4*c+k) -: 8], coef[(k - j + 4) % 4]);
        end
        m[127-8*(4*c+j) -: 8] = acc;
      end
    end
    return m;
  endfunction

  function automatic logic [127:0] encipher(logic [127:0] s);
    s = s ^ round_key(0);
    for (int r = 1; r <= 14; r++) begin
      s = sub_shift(s, 1'b0);
      if (r != 14) s = mix_cols(s, 1'b0);
      s = s ^ round_key(r);
    end
    return s;
  endfunction

  function automatic logic [127:0] decipher(logic [127:0] s);
    s = s ^ round_key(14);
    for (int r = 13; r >= 0; r--) begin
      s = sub_shift(s, 1'b1);
      s = s ^ round_key(r);
      if (r != 0) s = mix_cols(s, 1'b1);
    end
    return s;
  endfunction

  function automatic void push_result(logic [127:0] b, logic [4:0] vb, logic last, logic perr);
    codec_out_t e;
    e.res_hi = b[127:64];
    e.res_lo = b[63:0];
    e.vbytes = vb;
    e.last   = last;
    e.perr   = perr;
    expected_q.push_back(e);
  endfunction

  // chain, encrypt and keep the ciphertext as the next chain value
  function automatic logic [127:0] chain_encrypt(logic [127:0] b);
    chain = encipher(b ^ chain);
    return chain;
  endfunction

  function automatic void predict_block(logic [127:0] blk, logic [4:0] cnt, logic fin);
    logic [127:0] plain;
    logic [7:0]   pad;
    int           n;
    if (!in_msg) begin
      expand_round_keys();
      chain = {iv_hi, iv_lo};
    end
    in_msg = !fin;
    if (dec_mode) begin
      plain = decipher(blk) ^ chain;
      chain = blk;
      pad   = plain[7:0];
      if (!fin)                      push_result(plain, 5'd16, 1'b0, 1'b0);
      else if (pad == 0 || pad > 16) push_result(plain, 5'd16, 1'b1, 1'b1);
      else                           push_result(plain, 5'(16 - pad), 1'b1, 1'b0);
    end else if (!fin) begin
      push_result(chain_encrypt(blk), 5'd16, 1'b0, 1'b0);
    end else begin
      n = (cnt > 16) ? 16 : cnt;
      if (n < 16) begin
        for (int i = n; i < 16; i++) blk[127-8*i -: 8] = 8'(16 - n);
        push_result(chain_encrypt(blk), 5'd16, 1'b1, 1'b0);
      end else begin
        push_result(chain_encrypt(blk), 5'd16, 1'b0, 1'b0);
        push_result(chain_encrypt({16{8'h10}}), 5'd16, 1'b1, 1'b0);
      end
    end
  endfunction

  task automatic report(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic compare_result();
    codec_out_t e;
    if (expected_q.size() == 0) begin
      report("output item with nothing expected");
      return;
    end
    e = expected_q.pop_front();
    if (out_mon.result_high !== e.res_hi)
      report($sformatf("result_high got %h exp %h", out_mon.result_high, e.res_hi));
    if (out_mon.result_low !== e.res_lo)
      report($sformatf("result_low got %h exp %h", out_mon.result_low, e.res_lo));
    if (out_mon.valid_bytes !== e.vbytes)
      report($sformatf("valid_bytes got %0d exp %0d", out_mon.valid_bytes, e.vbytes));
    if (out_mon.run_end !== e.last)
      report($sformatf("run_end got %b exp %b", out_mon.run_end, e.last));
    if (out_mon.pad_error !== e.perr)
      report($sformatf("pad_error got %b exp %b", out_mon.pad_error, e.perr));
  endtask

  initial fail_count_o = 0;

  // track configuration, predict on input items, check output items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_mode = 1'b0;
      for (int i = 0; i < 4; i++) key_w[i] = '0;
      for (int i = 0; i < 30; i++) rkey[i] = '0;
      iv_hi  = '0;
      iv_lo  = '0;
      chain  = '0;
      in_msg = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MODE: dec_mode = cfg_data_i[0];
          CFG_KEY0: key_w[0] = cfg_data_i;
          CFG_KEY1: key_w[1] = cfg_data_i;
          CFG_KEY2: key_w[2] = cfg_data_i;
          CFG_KEY3: key_w[3] = cfg_data_i;
          CFG_IVHI: iv_hi    = cfg_data_i;
          CFG_IVLO: iv_lo    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_block({in_mon.block_high, in_mon.block_low}, in_mon.byte_count,
                      in_mon.final_block);
      if (out_mon.valid && out_mon.ready) compare_result();
    end
    pending_o = expected_q.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC codec testbench
// Drives message blocks through the codec in encrypt and decrypt mode under
// changing keys and IVs, replays captured ciphertext for decryption, and
// leaves the checking to the checker that sits beside the codec.
// ----------------------------------------------------------------------------
module testbench;
  import aes_cbc_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CfgAw-1:0] cfg_idx_i = '0;
  logic [63:0]      cfg_data_i = '0;
  int               fail_count;
  int               pending;
  bit               calm;
  int               sent_items;
  int               messages;
  int               phases;
  logic [127:0]     cipher_rec[$];
  logic [127:0]     cipher_saved[$];

  aes_cbc_in_if  in_ch ();
  aes_cbc_out_if out_ch ();

  aes256_cbc_pkcs7_codec u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  codec_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.block_high  = '0;
    in_ch.block_low   = '0;
    in_ch.byte_count  = '0;
    in_ch.final_block = 1'b0;
    out_ch.ready      = 1'b0;
  end

  // stall the result side at random unless in a calm stretch
  always @(negedge clk_i) out_ch.ready = calm || ($urandom_range(99) >= 35);

  // capture every output block for later replay
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) cipher_rec.push_back({out_ch.result_high, out_ch.result_low});
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [4:0] pick_count();
    case ($urandom_range(9))
      6:       return 5'd16;
      7:       return 5'($urandom_range(31, 17));
      8, 9:    return 5'($urandom_range(16));
      default: return 5'($urandom_range(15));
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // hold off until every expected item is back and the codec has gone quiet
  task automatic settle();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic send_block(logic [127:0] blk, logic [4:0] cnt, logic fin);
    while (!calm && $urandom_range(99) < 35) @(negedge clk_i);
    in_ch.block_high  = blk[127:64];
    in_ch.block_low   = blk[63:0];
    in_ch.byte_count  = cnt;
    in_ch.final_block = fin;
    in_ch.valid       = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    sent_items++;
    if (fin) messages++;
  endtask

  task automatic load_setting(logic [63:0] k0, k1, k2, k3, ivh, ivl);
    settle();
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_IVHI, ivh);
    write_reg(CFG_IVLO, ivl);
    phases++;
  endtask

  task automatic set_mode(logic dec);
    settle();
    write_reg(CFG_MODE, {63'd0, dec});
  endtask

  task automatic encrypt_message(int nblk);
    cipher_rec.delete();
    for (int k = 0; k < nblk; k++) begin
      if (k == nblk - 1) send_block({rand64(), rand64()}, pick_count(), 1'b1);
      else send_block({rand64(), rand64()}, 5'($urandom_range(31)), 1'b0);
    end
  endtask

  // replay the first n captured ciphertext blocks as one message
  task automatic replay_cipher(int n);
    for (int k = 0; k < n; k++)
      send_block(cipher_saved[k], 5'($urandom_range(31)), k == n - 1);
  endtask

  initial begin
    int nblk;
    calm = 1'b0;
    sent_items = 0;
    messages = 0;
    phases = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // all-zero key and IV, encrypt with every flavour of final block
    load_setting('0, '0, '0, '0, '0, '0);
    set_mode(1'b0);
    send_block('0, 5'd16, 1'b1);
    send_block('0, 5'd0, 1'b1);
    send_block('1, 5'd15, 1'b1);
    send_block('1, 5'd1, 1'b1);
    send_block({rand64(), rand64()}, 5'd31, 1'b1);
    send_block({rand64(), rand64()}, 5'd3, 1'b0);
    send_block({rand64(), rand64()}, 5'd17, 1'b1);

    // all-ones key and IV; plaintext ending in a zero byte and in 0x20
    load_setting('1, '1, '1, '1, '1, '1);
    cipher_rec.delete();
    send_block({rand64(), rand64() & ~64'hff}, 5'd0, 1'b0);
    send_block({rand64(), (rand64() & ~64'hff) | 64'h20}, 5'd31, 1'b0);
    send_block('1, 5'd16, 1'b1);
    settle();
    cipher_saved = cipher_rec;

    // decrypt: good padding, pad byte zero, pad byte above sixteen
    set_mode(1'b1);
    replay_cipher(4);
    replay_cipher(1);
    replay_cipher(2);

    // flip the mode in the middle of a message
    send_block({rand64(), rand64()}, 5'd0, 1'b0);
    set_mode(1'b0);
    send_block({rand64(), rand64()}, 5'd5, 1'b1);
    set_mode(1'b1);
    send_block({rand64(), rand64()}, 5'd16, 1'b1);

    // random settings, encrypt, then decrypt the captured ciphertext or random blocks
    while (sent_items < 500) begin
      calm = (phases >= 12 && phases < 18);
      load_setting(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
      set_mode(1'b0);
      encrypt_message($urandom_range(4, 1));
      if ($urandom_range(3) == 0) encrypt_message($urandom_range(3, 1));
      settle();
      cipher_saved = cipher_rec;
      set_mode(1'b1);
      case ($urandom_range(9))
        0, 1: replay_cipher($urandom_range(cipher_saved.size(), 1));
        2: begin
          nblk = $urandom_range(3, 1);
          for (int k = 0; k < nblk; k++)
            send_block({rand64(), rand64()}, 5'($urandom_range(31)), k == nblk - 1);
        end
        default: replay_cipher(cipher_saved.size());
      endcase
    end

    calm = 1'b0;
    settle();
    $display("run covered %0d blocks in %0d messages over %0d key/IV settings,",
             sent_items, messages, phases);
    $display("both modes, padding edge cases and mid-message mode changes");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
